[src/assert_macros.svh]
// Assertion macros shared by the checker. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/ape_pkg.sv]
package ape_pkg;

    localparam int SideWidth = 32;
    localparam int DenWidth  = 64;
    localparam int RootBits  = 34;
    localparam int QWidth    = 130;
    localparam int PWidth    = 98;
    localparam int TWidth    = 134;

    typedef enum logic
    {
        OP_SQUARE = 1'b0,
        OP_RECT   = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                zero;
        logic [63:0]         wanted;
        logic [QWidth-1:0]   qx;
        logic [DenWidth-1:0] dx;
        logic [QWidth-1:0]   qz;
        logic [DenWidth-1:0] dz;
    } job_t;

    typedef struct packed
    {
        logic                ovf;
        logic [RootBits-1:0] r;
        logic [QWidth-1:0]   rem;
        logic [PWidth-1:0]   p;
        logic [DenWidth-1:0] d;
    } lane_t;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return {32'd0, a} * {32'd0, b};
    endfunction

    function automatic logic [127:0] sum_partials(input logic [63:0] ll,
                                                  input logic [63:0] lh,
                                                  input logic [63:0] hl,
                                                  input logic [63:0] hh);
        return {64'd0, ll} + ({64'd0, lh} << 32) + ({64'd0, hl} << 32) + {hh, 64'd0};
    endfunction

endpackage

[src/ape_if.sv]
interface ape_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] first_extent;
    logic [63:0] second_extent;
    logic [31:0] closed_side;
    logic        aspect_known;

    modport source (output valid, opcode, first_extent, second_extent, closed_side,
                    aspect_known, input ready);
    modport sink   (input valid, opcode, first_extent, second_extent, closed_side,
                    aspect_known, output ready);
endinterface

interface ape_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_valid;
    logic [31:0] side_x;
    logic [31:0] side_z;
    logic [63:0] wanted_area;
    logic [63:0] achieved_area;
    logic        delta_negative;
    logic [63:0] delta_magnitude;

    modport source (output valid, result_valid, side_x, side_z, wanted_area, achieved_area,
                    delta_negative, delta_magnitude, input ready);
    modport sink   (input valid, result_valid, side_x, side_z, wanted_area, achieved_area,
                    delta_negative, delta_magnitude, output ready);
endinterface

[src/ape_front.sv]
module ape_front
(
    input  logic          clk,
    input  logic          rst_n,
    ape_req_if.sink       req,
    output logic          push_valid,
    output ape_pkg::job_t push_job,
    input  logic          push_ready
);
    import ape_pkg::*;

    logic        advance;

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [63:0] s1_a_reg;
    logic [63:0] s1_b_reg;
    logic [63:0] s1_csq_reg;
    logic        s1_aspect_reg;
    logic        s1_zero_reg;

    logic        s2_valid_reg;
    op_t         s2_op_reg;
    logic [63:0] s2_csq_reg;
    logic        s2_zero_reg;
    logic [63:0] s2_dx_reg;
    logic [63:0] s2_dz_reg;
    logic [63:0] s2_ppx_reg [4];
    logic [63:0] s2_ppz_reg [4];

    logic        s3_valid_reg;
    job_t        s3_job_reg;

    logic [63:0] mx_a;
    logic [63:0] mx_b;
    logic [63:0] mz_a;
    logic [63:0] mz_b;
    logic [63:0] dx_sel;
    logic [63:0] dz_sel;
    logic [127:0] nx;
    logic [127:0] nz;
    job_t        job_next;

    assign advance    = !s3_valid_reg || push_ready;
    assign req.ready  = advance;
    assign push_valid = s3_valid_reg;
    assign push_job   = s3_job_reg;

    always_comb
    begin
        mx_a   = s1_csq_reg;
        mx_b   = 64'd1;
        mz_a   = s1_csq_reg;
        mz_b   = 64'd1;
        dx_sel = 64'd1;
        dz_sel = 64'd1;
        unique case (s1_op_reg)
            OP_SQUARE:
            begin
                mx_a = s1_a_reg;
                mx_b = s1_b_reg;
                mz_a = s1_a_reg;
                mz_b = s1_b_reg;
            end
            OP_RECT:
            begin
                if (s1_aspect_reg)
                begin
                    mx_b   = s1_a_reg;
                    mz_b   = s1_b_reg;
                    dx_sel = s1_b_reg;
                    dz_sel = s1_a_reg;
                end
            end
            default:
            begin
                mx_a = s1_csq_reg;
            end
        endcase
    end

    always_comb
    begin
        nx              = sum_partials(s2_ppx_reg[0], s2_ppx_reg[1], s2_ppx_reg[2], s2_ppx_reg[3]);
        nz              = sum_partials(s2_ppz_reg[0], s2_ppz_reg[1], s2_ppz_reg[2], s2_ppz_reg[3]);
        job_next.zero   = s2_zero_reg || ((s2_op_reg == OP_SQUARE) && (nx[127:64] != 64'd0));
        job_next.wanted = (s2_op_reg == OP_SQUARE) ? nx[63:0] : s2_csq_reg;
        job_next.qx     = {nx, 2'b00};
        job_next.qz     = {nz, 2'b00};
        job_next.dx     = s2_dx_reg;
        job_next.dz     = s2_dz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= op_t'(req.opcode);
            s1_a_reg      <= req.first_extent;
            s1_b_reg      <= req.second_extent;
            s1_csq_reg    <= mul32(req.closed_side, req.closed_side);
            s1_aspect_reg <= (req.opcode == OP_RECT) && req.aspect_known
                             && (req.first_extent != 64'd0) && (req.second_extent != 64'd0);
            s1_zero_reg   <= (req.opcode == OP_SQUARE)
                             ? ((req.first_extent == 64'd0) || (req.second_extent == 64'd0))
                             : (req.closed_side == 32'd0);

            s2_op_reg     <= s1_op_reg;
            s2_csq_reg    <= s1_csq_reg;
            s2_zero_reg   <= s1_zero_reg;
            s2_dx_reg     <= dx_sel;
            s2_dz_reg     <= dz_sel;
            s2_ppx_reg[0] <= mul32(mx_a[31:0],  mx_b[31:0]);
            s2_ppx_reg[1] <= mul32(mx_a[31:0],  mx_b[63:32]);
            s2_ppx_reg[2] <= mul32(mx_a[63:32], mx_b[31:0]);
            s2_ppx_reg[3] <= mul32(mx_a[63:32], mx_b[63:32]);
            s2_ppz_reg[0] <= mul32(mz_a[31:0],  mz_b[31:0]);
            s2_ppz_reg[1] <= mul32(mz_a[31:0],  mz_b[63:32]);
            s2_ppz_reg[2] <= mul32(mz_a[63:32], mz_b[31:0]);
            s2_ppz_reg[3] <= mul32(mz_a[63:32], mz_b[63:32]);

            s3_job_reg    <= job_next;
        end
    end

endmodule

[src/ape_queue.sv]
module ape_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ape_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ape_pkg::job_t pop_job
);
    import ape_pkg::*;

    localparam int Depth = 2;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);

    job_t           entry_reg [Depth];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != CW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/ape_root_lane.sv]
module ape_root_lane
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [ape_pkg::QWidth-1:0]    q,
    input  logic [ape_pkg::DenWidth-1:0]  d,
    output logic [ape_pkg::RootBits-1:0]  r,
    output logic                          rem_zero,
    output logic                          ovf
);
    import ape_pkg::*;

    // Finds the largest r below 2^RootBits with r*r*d <= q, one root bit per stage.
    // p tracks r*d so that each trial is a shift and an add.
    lane_t st_reg  [RootBits+1];
    lane_t st_next [RootBits+1];

    always_comb
    begin
        st_next[0].ovf = (TWidth'(q) >= (TWidth'(d) << (2 * RootBits)));
        st_next[0].r   = '0;
        st_next[0].rem = q;
        st_next[0].p   = '0;
        st_next[0].d   = d;
    end

    for (genvar i = 0; i < RootBits; i++)
    begin : g_step
        localparam int J = RootBits - 1 - i;
        logic [TWidth-1:0] trial;
        logic [TWidth-1:0] rem_w;

        always_comb
        begin
            trial        = (TWidth'(st_reg[i].p) << (J + 1)) + (TWidth'(st_reg[i].d) << (2 * J));
            rem_w        = TWidth'(st_reg[i].rem);
            st_next[i+1] = st_reg[i];
            if (trial <= rem_w)
            begin
                st_next[i+1].rem  = QWidth'(rem_w - trial);
                st_next[i+1].p    = st_reg[i].p + (PWidth'(st_reg[i].d) << J);
                st_next[i+1].r[J] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= RootBits; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign r        = st_reg[RootBits].r;
    assign rem_zero = (st_reg[RootBits].rem == '0);
    assign ovf      = st_reg[RootBits].ovf;

endmodule

[src/ape_back.sv]
module ape_back
#(
    parameter logic [31:0] MAX_EXTENT = 32'hFFFF_FFFF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  ape_pkg::job_t pop_job,
    ape_rsp_if.source     rsp
);
    import ape_pkg::*;

    localparam logic [RootBits-1:0] TwiceMax = {1'b0, MAX_EXTENT, 1'b0};

    logic                en;

    logic                sv_valid_reg  [RootBits+1];
    logic                sv_zero_reg   [RootBits+1];
    logic [63:0]         sv_wanted_reg [RootBits+1];

    logic [RootBits-1:0] rx;
    logic [RootBits-1:0] rz;
    logic                rx_rem_zero;
    logic                rz_rem_zero;
    logic                rx_ovf;
    logic                rz_ovf;

    logic                f1_valid_reg;
    logic                f1_zero_reg;
    logic [63:0]         f1_wanted_reg;
    logic [31:0]         f1_x_reg;
    logic [31:0]         f1_z_reg;

    logic                f2_valid_reg;
    logic                f2_zero_reg;
    logic                f2_ok_reg;
    logic [63:0]         f2_wanted_reg;
    logic [31:0]         f2_x_reg;
    logic [31:0]         f2_z_reg;
    logic [63:0]         f2_area_reg;

    logic                out_valid_reg;
    logic                out_result_valid_reg;
    logic [31:0]         out_side_x_reg;
    logic [31:0]         out_side_z_reg;
    logic [63:0]         out_wanted_reg;
    logic [63:0]         out_achieved_reg;
    logic                out_negative_reg;
    logic [63:0]         out_magnitude_reg;

    logic                out_result_valid_next;
    logic [31:0]         out_side_x_next;
    logic [31:0]         out_side_z_next;
    logic [63:0]         out_wanted_next;
    logic [63:0]         out_achieved_next;
    logic                out_negative_next;
    logic [63:0]         out_magnitude_next;

    function automatic logic [31:0] side_of(input logic [RootBits-1:0] root,
                                            input logic rem_is_zero,
                                            input logic over);
        logic                fail;
        logic [RootBits:0]   half;
        fail = over || (root > TwiceMax) || ((root == TwiceMax) && !rem_is_zero);
        half = ({1'b0, root} + 1'b1) >> 1;
        return fail ? 32'd0 : half[31:0];
    endfunction

    assign en        = !out_valid_reg || rsp.ready;
    assign pop_ready = en;

    ape_root_lane u_lane_x
    (
        .clk      (clk),
        .en       (en),
        .q        (pop_job.qx),
        .d        (pop_job.dx),
        .r        (rx),
        .rem_zero (rx_rem_zero),
        .ovf      (rx_ovf)
    );

    ape_root_lane u_lane_z
    (
        .clk      (clk),
        .en       (en),
        .q        (pop_job.qz),
        .d        (pop_job.dz),
        .r        (rz),
        .rem_zero (rz_rem_zero),
        .ovf      (rz_ovf)
    );

    always_comb
    begin
        out_result_valid_next = 1'b0;
        out_side_x_next       = 32'd0;
        out_side_z_next       = 32'd0;
        out_wanted_next       = 64'd0;
        out_achieved_next     = 64'd0;
        out_negative_next     = 1'b0;
        out_magnitude_next    = 64'd0;
        if (!f2_zero_reg)
        begin
            out_side_x_next = f2_x_reg;
            out_side_z_next = f2_z_reg;
            out_wanted_next = f2_wanted_reg;
            if (f2_ok_reg)
            begin
                out_result_valid_next = 1'b1;
                out_achieved_next     = f2_area_reg;
                if (f2_area_reg < f2_wanted_reg)
                begin
                    out_negative_next  = 1'b1;
                    out_magnitude_next = f2_wanted_reg - f2_area_reg;
                end
                else
                begin
                    out_magnitude_next = f2_area_reg - f2_wanted_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RootBits; k++)
            begin
                sv_valid_reg[k] <= 1'b0;
            end
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_valid_reg[0] <= pop_valid;
            for (int k = 0; k < RootBits; k++)
            begin
                sv_valid_reg[k+1] <= sv_valid_reg[k];
            end
            f1_valid_reg  <= sv_valid_reg[RootBits];
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_zero_reg[0]   <= pop_job.zero;
            sv_wanted_reg[0] <= pop_job.wanted;
            for (int k = 0; k < RootBits; k++)
            begin
                sv_zero_reg[k+1]   <= sv_zero_reg[k];
                sv_wanted_reg[k+1] <= sv_wanted_reg[k];
            end

            f1_zero_reg   <= sv_zero_reg[RootBits];
            f1_wanted_reg <= sv_wanted_reg[RootBits];
            f1_x_reg      <= side_of(rx, rx_rem_zero, rx_ovf);
            f1_z_reg      <= side_of(rz, rz_rem_zero, rz_ovf);

            f2_zero_reg   <= f1_zero_reg;
            f2_ok_reg     <= !f1_zero_reg && (f1_x_reg != 32'd0) && (f1_z_reg != 32'd0);
            f2_wanted_reg <= f1_wanted_reg;
            f2_x_reg      <= f1_x_reg;
            f2_z_reg      <= f1_z_reg;
            f2_area_reg   <= mul32(f1_x_reg, f1_z_reg);

            out_result_valid_reg <= out_result_valid_next;
            out_side_x_reg       <= out_side_x_next;
            out_side_z_reg       <= out_side_z_next;
            out_wanted_reg       <= out_wanted_next;
            out_achieved_reg     <= out_achieved_next;
            out_negative_reg     <= out_negative_next;
            out_magnitude_reg    <= out_magnitude_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.result_valid    = out_result_valid_reg;
    assign rsp.side_x          = out_side_x_reg;
    assign rsp.side_z          = out_side_z_reg;
    assign rsp.wanted_area     = out_wanted_reg;
    assign rsp.achieved_area   = out_achieved_reg;
    assign rsp.delta_negative  = out_negative_reg;
    assign rsp.delta_magnitude = out_magnitude_reg;

endmodule

[src/area_preserving_extent.sv]
// Area-preserving extent converter.
// A request beat on req carries an opcode, two extents, a square side and an
// aspect flag. Opcode square turns a rectangle into the nearest-rounded square
// of equal area; opcode rect turns a square side into a rectangle with the
// given aspect ratio. Each request gives exactly one response beat on rsp,
// in order, with both sides, both areas and the signed area difference.
// A new request is taken every cycle while the front is not stalled. A
// response passes through three front stages with the 64 by 64 bit
// multiplications, the queue, 35 stages of the bit-per-stage root lanes
// and three finishing stages.
// The front stalls only when the two-entry queue is full; the back stalls
// as a whole while a response waits on rsp, and the queue lets the front keep
// accepting meanwhile. Reset clears every valid flag and empties the queue;
// no results are pending afterwards.
module area_preserving_extent
#(
    parameter logic [31:0] MAX_EXTENT = 32'hFFFF_FFFF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ape_req_if.sink   req,
    ape_rsp_if.source rsp
);
    import ape_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    ape_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    ape_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    ape_back #(.MAX_EXTENT(MAX_EXTENT)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .rsp       (rsp)
    );

endmodule

[src/ape_checker.sv]
`include "assert_macros.svh"

module ape_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        result_valid,
    input logic [31:0] side_x,
    input logic [31:0] side_z,
    input logic [63:0] achieved_area,
    input logic        delta_negative,
    input logic [63:0] delta_magnitude
);

    `ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_NEXT(a_sides_hold, rsp_valid && !rsp_ready, $stable(side_x) && $stable(side_z))
    `ASSERT_NOW(a_invalid_quiet, rsp_valid && !result_valid, achieved_area == 64'd0 && delta_magnitude == 64'd0 && !delta_negative)
    `ASSERT_NOW(a_valid_sides, rsp_valid && result_valid, side_x != 32'd0 && side_z != 32'd0)

endmodule

bind area_preserving_extent ape_checker u_ape_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .result_valid    (rsp.result_valid),
    .side_x          (rsp.side_x),
    .side_z          (rsp.side_z),
    .achieved_area   (rsp.achieved_area),
    .delta_negative  (rsp.delta_negative),
    .delta_magnitude (rsp.delta_magnitude)
);
